// ----- hdl/rmvs_pkg.sv -----
// Package for the running mean and variance statistics block.
// Holds the sequencer state type, the unit control struct and width constants; no dependencies.
package rmvs_pkg;

	localparam int unsigned TotalW = 64;
	localparam int unsigned DevW   = 64;
	localparam int unsigned StdW   = 31;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DIV  = 7'b0000010,
		ST_MUL  = 7'b0000100,
		ST_ACC  = 7'b0001000,
		ST_VDIV = 7'b0010000,
		ST_SQRT = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} unit_ctl_t;

endpackage

// ----- hdl/rmvs_divider.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on rmvs_pkg for the control struct.
module rmvs_divider #(
	parameter int unsigned NW = 64,
	parameter int unsigned DW = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rmvs_pkg::unit_ctl_t ctl_in,
	input  logic [NW-1:0]      numer,
	input  logic [DW-1:0]      denom,
	output logic [NW-1:0]      quot,
	output logic               done
);
	localparam int unsigned CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [DW:0]   trial;
	logic [DW:0]   shifted;

	// Shift in the next numerator bit and try a subtract.
	assign shifted = {rem_q[DW-1:0], num_q[NW-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl_in.start) begin
			run_q <= 1'b1;
			cnt_q <= CW'(NW);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
		end else if (run_q) begin
			if (!trial[DW]) begin
				rem_q <= trial;
				num_q <= {num_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				num_q <= {num_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quot = num_q;
	assign done = !run_q && !ctl_in.start && !ctl_in.busy;
endmodule

// ----- hdl/rmvs_sqrt.sv -----
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on rmvs_pkg for the control struct.
module rmvs_sqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  rmvs_pkg::unit_ctl_t ctl_in,
	input  logic [63:0]         radicand,
	output logic [31:0]         root,
	output logic                done
);
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [33:0] cur;
	logic [33:0] trial;

	// Bring down two bits and test against 4*root+1.
	assign cur   = {rem_q[31:0], rad_q[63:62]};
	assign trial = cur - {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl_in.start) begin
			run_q <= 1'b1;
			cnt_q <= 6'd32;
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 6'd1) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (!trial[33]) begin
				rem_q  <= trial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= cur;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign done = !run_q && !ctl_in.start && !ctl_in.busy;
endmodule

// ----- hdl/rmvs_multiplier.sv -----
// Shift-and-add multiplier, one multiplier bit per cycle, unsigned.
// Depends on rmvs_pkg for the control struct.
module rmvs_multiplier #(
	parameter int unsigned AW = 49
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rmvs_pkg::unit_ctl_t ctl_in,
	input  logic [AW-1:0]       op_a,
	input  logic [AW-1:0]       op_b,
	output logic [2*AW-1:0]     prod,
	output logic                done
);
	localparam int unsigned CW = $clog2(AW + 1);

	logic [2*AW-1:0] acc_q;
	logic [2*AW-1:0] mcand_q;
	logic [AW-1:0]   mplier_q;
	logic [CW-1:0]   cnt_q;
	logic            run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl_in.start) begin
			run_q <= 1'b1;
			cnt_q <= CW'(AW);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	// Add the shifted multiplicand when the low multiplier bit is set.
	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			acc_q    <= '0;
			mcand_q  <= {{AW{1'b0}}, op_a};
			mplier_q <= op_b;
		end else if (run_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[2*AW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[AW-1:1]};
		end
	end

	assign prod = acc_q;
	assign done = !run_q && !ctl_in.start && !ctl_in.busy;
endmodule

// ----- hdl/running_mean_variance_stats.sv -----
// Running mean and variance statistics, top level (Welford update).
// Uses rmvs_pkg, rmvs_divider, rmvs_multiplier and rmvs_sqrt.
//
// Usage: one signed sample beat enters on the s_axis channel; after its
// update one result beat leaves on m_axis carrying count, min, max, total,
// mean, deviation sum, standard deviation and the sticky saturation flag.
// One sample is processed at a time. A sample passes through serial mean
// division (64-bit divider), serial deviation multiply, the accumulate
// state, serial variance division and square root, then the output
// state; the next sample is accepted once the sequencer is idle again.
// The first sample after reset skips the units and goes through the
// accumulate and output states only. The serial divider and multiplier
// work one bit per cycle.
// The result sits in an output register; the next sample is accepted as
// soon as the update finishes, even while that result still waits, and
// a second finished result waits for the first to be taken.
// Reset clears the count, the accumulators and the flag; the first
// sample after reset seeds min, max and mean.
module running_mean_variance_stats #(
	parameter int unsigned COUNT_BITS  = 32,
	parameter int unsigned SAMPLE_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,   // [31:0] sample
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] sample_count, [63:32] minimum, [95:64] maximum,
	// [159:96] running_total, [191:160] mean, [254:192] deviation_sum,
	// [285:255] std_dev, [286] saturated, [287] zero
	output logic [287:0] m_axis_tdata
);
	localparam int unsigned SW = SAMPLE_BITS;
	localparam int unsigned DLW = SW + 2;  // delta / residual width, signed
	localparam int unsigned MW = DLW;      // magnitude width
	localparam logic [COUNT_BITS-1:0] CntMax = '1;
	localparam logic [63:0] DevMax = 64'h7FFF_FFFF_FFFF_FFFF;

	rmvs_pkg::state_t state_q;

	logic [COUNT_BITS-1:0] count_q;
	logic signed [SW-1:0]  min_q, max_q, mean_q, x_q;
	logic signed [63:0]    total_q;
	logic [63:0]           devsum_q;
	logic                  sat_q;
	logic signed [DLW-1:0] delta_q;
	logic [63:0]           std_q;
	logic                  ob_valid_q;
	logic [287:0]          ob_data_q;

	rmvs_pkg::unit_ctl_t div_ctl, mul_ctl, sqrt_ctl;
	logic        div_done, mul_done, sqrt_done;
	logic [63:0] div_num;
	logic [63:0] div_quot;
	logic [63:0] div_den;
	logic [2*MW-1:0] mul_prod;
	logic [31:0] sqrt_root;
	logic        busy_q;

	logic signed [SW-1:0] x_in;
	logic signed [63:0]   x_ext;
	logic signed [64:0]   total_sum;
	logic signed [DLW-1:0] mean_new, resid;
	logic [MW-1:0]        mag_a, mag_b;
	logic [63:0]          q_mag;
	logic [64:0]          dev_sum;
	logic                 prod_ovf;
	logic                 accept_in;

	assign x_in      = SW'(s_axis_tdata);
	assign accept_in = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == rmvs_pkg::ST_IDLE);

	// Shared divider: mean step uses |delta|/count, variance uses devsum/(count-1).
	assign div_den = (state_q == rmvs_pkg::ST_DIV) ? 64'(count_q) : 64'(count_q - 1'b1);
	assign div_num = (state_q == rmvs_pkg::ST_DIV)
		? 64'(delta_q[DLW-1] ? -delta_q : delta_q) : devsum_q;

	rmvs_divider #(.NW(64), .DW(64)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl_in(div_ctl),
		.numer(div_num), .denom(div_den), .quot(div_quot), .done(div_done));

	assign q_mag    = div_quot;
	assign mean_new = delta_q[DLW-1] ? DLW'(mean_q) - DLW'(q_mag) : DLW'(mean_q) + DLW'(q_mag);
	assign resid    = DLW'(x_q) - mean_new;
	assign mag_a    = delta_q[DLW-1] ? MW'(-delta_q) : MW'(delta_q);
	assign mag_b    = resid[DLW-1] ? MW'(-resid) : MW'(resid);

	rmvs_multiplier #(.AW(MW)) u_mul (
		.clk(clk), .arst_n(arst_n), .ctl_in(mul_ctl),
		.op_a(mag_a), .op_b(mag_b), .prod(mul_prod), .done(mul_done));

	rmvs_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .ctl_in(sqrt_ctl),
		.radicand(div_quot), .root(sqrt_root), .done(sqrt_done));

	// Saturation checks on the product and the deviation sum.
	always_comb begin
		prod_ovf = 1'b0;
		for (int i = 63; i < 2 * MW; i++) begin
			prod_ovf = prod_ovf | mul_prod[i];
		end
	end
	assign dev_sum = {1'b0, devsum_q} + {1'b0, 64'(mul_prod)};

	assign x_ext     = 64'(x_in);
	assign total_sum = {total_q[63], total_q} + {x_ext[63], x_ext};

	// Start pulses: one cycle on entry to each unit's state.
	assign div_ctl.start  = busy_q == 1'b0 &&
		(state_q == rmvs_pkg::ST_DIV || state_q == rmvs_pkg::ST_VDIV);
	assign div_ctl.busy   = 1'b0;
	assign mul_ctl.start  = busy_q == 1'b0 && state_q == rmvs_pkg::ST_MUL;
	assign mul_ctl.busy   = 1'b0;
	assign sqrt_ctl.start = busy_q == 1'b0 && state_q == rmvs_pkg::ST_SQRT;
	assign sqrt_ctl.busy  = 1'b0;

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rmvs_pkg::ST_IDLE;
			busy_q     <= 1'b0;
			count_q    <= '0;
			total_q    <= '0;
			devsum_q   <= '0;
			sat_q      <= 1'b0;
			ob_valid_q <= 1'b0;
		end else begin
			if (state_q == rmvs_pkg::ST_OUT && (!ob_valid_q || m_axis_tready)) begin
				ob_valid_q <= 1'b1;
			end else if (ob_valid_q && m_axis_tready) begin
				ob_valid_q <= 1'b0;
			end
			case (state_q)
				rmvs_pkg::ST_IDLE: begin
					if (accept_in) begin
						// Total always accumulates with clamping.
						if (total_sum[64] != total_sum[63]) begin
							total_q <= total_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
						end else begin
							total_q <= total_sum[63:0];
						end
						// A clamped total or a held count sets the flag.
						if (total_sum[64] != total_sum[63] ||
							(count_q != '0 && count_q == CntMax)) begin
							sat_q <= 1'b1;
						end
						if (count_q == '0) begin
							count_q  <= COUNT_BITS'(1);
							devsum_q <= '0;
							state_q  <= rmvs_pkg::ST_ACC;
						end else begin
							if (count_q != CntMax) begin
								count_q <= count_q + 1'b1;
							end
							state_q <= rmvs_pkg::ST_DIV;
						end
					end
				end
				rmvs_pkg::ST_DIV: begin
					if (busy_q && div_done) begin
						busy_q  <= 1'b0;
						state_q <= rmvs_pkg::ST_MUL;
					end else begin
						busy_q <= 1'b1;
					end
				end
				rmvs_pkg::ST_MUL: begin
					if (busy_q && mul_done) begin
						busy_q <= 1'b0;
						if (prod_ovf || dev_sum[64] || dev_sum[63]) begin
							devsum_q <= DevMax;
							sat_q    <= 1'b1;
						end else begin
							devsum_q <= dev_sum[63:0];
						end
						state_q <= rmvs_pkg::ST_ACC;
					end else begin
						busy_q <= 1'b1;
					end
				end
				rmvs_pkg::ST_ACC: begin
					state_q <= (count_q >= COUNT_BITS'(2)) ? rmvs_pkg::ST_VDIV
						: rmvs_pkg::ST_OUT;
				end
				rmvs_pkg::ST_VDIV: begin
					if (busy_q && div_done) begin
						busy_q  <= 1'b0;
						state_q <= rmvs_pkg::ST_SQRT;
					end else begin
						busy_q <= 1'b1;
					end
				end
				rmvs_pkg::ST_SQRT: begin
					if (busy_q && sqrt_done) begin
						busy_q  <= 1'b0;
						state_q <= rmvs_pkg::ST_OUT;
					end else begin
						busy_q <= 1'b1;
					end
				end
				rmvs_pkg::ST_OUT: begin
					if (!ob_valid_q || m_axis_tready) begin
						state_q <= rmvs_pkg::ST_IDLE;
					end
				end
				default: state_q <= rmvs_pkg::ST_IDLE;
			endcase
		end
	end

	// Payload registers: sample, min, max, mean, delta, standard deviation and result beat.
	always_ff @(posedge clk) begin
		case (state_q)
			rmvs_pkg::ST_IDLE: begin
				if (accept_in) begin
					x_q     <= x_in;
					std_q   <= '0;
					delta_q <= DLW'(x_in) - DLW'(mean_q);
					if (count_q == '0) begin
						min_q  <= x_in;
						max_q  <= x_in;
						mean_q <= x_in;
					end else begin
						if (x_in < min_q) min_q <= x_in;
						if (x_in > max_q) max_q <= x_in;
					end
				end
			end
			rmvs_pkg::ST_MUL: begin
				if (busy_q && mul_done) begin
					mean_q <= SW'(mean_new);
				end
			end
			rmvs_pkg::ST_SQRT: begin
				if (busy_q && sqrt_done) begin
					std_q <= 64'(sqrt_root);
				end
			end
			rmvs_pkg::ST_OUT: begin
				if (!ob_valid_q || m_axis_tready) begin
					ob_data_q[31:0]    <= (COUNT_BITS > 32 && (count_q >> 32) != '0)
						? 32'hFFFF_FFFF : 32'(count_q);
					ob_data_q[63:32]   <= 32'(min_q);
					ob_data_q[95:64]   <= 32'(max_q);
					ob_data_q[159:96]  <= total_q;
					ob_data_q[191:160] <= 32'(mean_q);
					ob_data_q[254:192] <= devsum_q[62:0];
					ob_data_q[285:255] <= (std_q > 64'(32'h7FFF_FFFF))
						? 31'h7FFF_FFFF : std_q[30:0];
					ob_data_q[286]     <= sat_q;
					ob_data_q[287]     <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = ob_valid_q;
	assign m_axis_tdata  = ob_data_q;
endmodule

// ----- hdl/rmvs_checker.sv -----
// Port-level checker for the statistics block, bound to the top level.
// Depends only on the top-level ports.
module rmvs_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [287:0] m_axis_tdata
);
	// A stalled result beat holds its data.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// A sample accepted is never followed at once by another.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("sample taken back to back");

	// Standard deviation is zero while only one sample exists.
	a_sd: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[31:0] == 32'd1 |-> m_axis_tdata[285:255] == '0)
		else $error("nonzero deviation with one sample");

	// Minimum never exceeds maximum.
	a_mm: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $signed(m_axis_tdata[63:32]) <= $signed(m_axis_tdata[95:64]))
		else $error("minimum above maximum");
endmodule

bind running_mean_variance_stats rmvs_checker u_rmvs_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata));
